// ===== sv/packet_filter_rule_table_unit_macros.svh =====
// assertion macros for the packet filter rule table
`ifndef PACKET_FILTER_RULE_TABLE_UNIT_MACROS_SVH
`define PACKET_FILTER_RULE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define PFRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define PFRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pfrt_pkg.sv =====
// types, codes and match function for the packet filter rule table
`default_nettype none

package pfrt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int COUNT_OUT_W = 7;

	localparam logic [1:0] FN_CHECK = 2'd0;
	localparam logic [1:0] FN_ADD   = 2'd1;
	localparam logic [1:0] FN_DEL   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] ip_addr;
		logic [7:0]  protocol;
		logic [15:0] port;
	} in_t;

	typedef struct packed {
		logic                   drop;
		logic [1:0]             status;
		logic [COUNT_OUT_W-1:0] rule_count;
	} out_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip_addr;
		logic [7:0]  protocol;
		logic [15:0] port;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	// rule fields of zero match anything; a nonzero port needs tcp or udp
	function automatic logic entry_hits(entry_t e, in_t p);
		logic addr_ok;
		logic proto_ok;
		logic port_ok;
		addr_ok  = (e.ip_addr == 32'd0) || (e.ip_addr == p.ip_addr);
		proto_ok = (e.protocol == 8'd0) || (e.protocol == p.protocol);
		port_ok  = (e.port == 16'd0) ||
			(((p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP)) &&
			(e.port == p.port));
		return addr_ok && proto_ok && port_ok;
	endfunction

	// per-function condition for stopping the scan at an entry
	function automatic logic rule_hit(entry_t e, in_t p);
		logic h;
		case (p.func)
			FN_CHECK: h = e.valid && entry_hits(e, p);
			FN_ADD:   h = !e.valid;
			FN_DEL:   h = e.valid && (e.ip_addr == p.ip_addr) &&
				(e.protocol == p.protocol) && (e.port == p.port);
			default:  h = 1'b0;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== sv/packet_filter_rule_table_unit.sv =====
// Packet filter rule table: top level with scan sequencer and result register.
// Rules live in a single-port-read memory that is walked one entry per cycle.
// A check, add or delete transaction stops at the first entry that satisfies
// it, or after the last entry if none does, and its result is then loaded into
// the output register, or into a holding register while the output is stalled;
// no new item is accepted until that result is loaded. After reset a clearing
// pass invalidates every entry, with in_stall high throughout. A result may wait
// in the output register while the next item is accepted; a second finished
// result holds in_stall high until the first is taken.
`default_nettype none

module packet_filter_rule_table_unit #(
	parameter int TABLE_DEPTH = pfrt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire pfrt_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output pfrt_pkg::out_t      out_data
);
	import pfrt_pkg::*;

	`include "packet_filter_rule_table_unit_macros.svh"

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t             st_q, st_d;
	in_t                item_q;
	logic [IDX_W-1:0]   idx_q;
	logic               issue_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	out_t               res_q, res;
	logic               out_valid_q;
	out_t               out_q;

	entry_t             rdata_s1;
	logic               rd_en;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;

	logic               hit, last, done, out_free, load_out, accept;

	pfrt_rule_mem #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IDX_W(IDX_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(rd_en),
		.raddr(idx_q),
		.rdata(rdata_s1)
	);

	assign in_stall  = (st_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign hit  = pend_s1 && rule_hit(rdata_s1, item_q);
	assign last = pend_s1 && (idx_s1 == LAST_IDX);
	assign done = (st_q == S_SCAN) && (hit || last);

	always_comb begin
		st_d      = st_q;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		cnt_d     = cnt_q;
		load_out  = 1'b0;
		res.drop       = (item_q.func == FN_CHECK) && hit;
		res.status     = ST_OK;
		if ((item_q.func == FN_ADD) && !hit) begin
			res.status = ST_FULL;
		end
		if ((item_q.func == FN_DEL) && !hit) begin
			res.status = ST_MISSING;
		end
		if (hit && (item_q.func == FN_ADD)) begin
			cnt_d = cnt_q + CNT_W'(1);
		end
		if (hit && (item_q.func == FN_DEL) && (cnt_q != '0)) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
		res.rule_count = COUNT_OUT_W'(cnt_d);
		case (st_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				if (idx_q == LAST_IDX) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					st_d = S_SCAN;
				end
			end
			S_SCAN: begin
				rd_en = issue_q && !done;
				if (done) begin
					if (hit && ((item_q.func == FN_ADD) || (item_q.func == FN_DEL))) begin
						mem_we    = 1'b1;
						mem_wdata = '{valid: (item_q.func == FN_ADD),
							ip_addr: item_q.ip_addr,
							protocol: item_q.protocol,
							port: item_q.port};
					end
					load_out = out_free;
					st_d     = out_free ? S_IDLE : S_HOLD;
				end
			end
			S_HOLD: begin
				load_out = out_free;
				if (out_free) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLEAR;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			pend_s1     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			pend_s1 <= rd_en;
			if (st_q == S_CLEAR) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
			end else if (accept) begin
				idx_q   <= '0;
				issue_q <= 1'b1;
			end else if (rd_en) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			if (done) begin
				cnt_q   <= cnt_d;
				issue_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			item_q <= in_data;
		end
		if (done && !out_free) begin
			res_q <= res;
		end
		if (load_out) begin
			out_q <= (st_q == S_HOLD) ? res_q : res;
		end
	end

	`PFRT_ASSERT_NXT(a_accept_scan, accept, st_q == S_SCAN, "accepted item did not start a scan")
	`PFRT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "rule count exceeds depth")
	`PFRT_ASSERT_IMP(a_we_state, mem_we, (st_q == S_SCAN) || (st_q == S_CLEAR), "stray table write")
	`PFRT_ASSERT_NXT(a_del_count, done && hit && (item_q.func == FN_DEL), cnt_q == $past(cnt_q) - CNT_W'(1), "delete did not lower count")

endmodule

`default_nettype wire

// ===== sv/pfrt_rule_mem.sv =====
// rule storage: one write port, one registered read port
`default_nettype none

module pfrt_rule_mem #(
	parameter int TABLE_DEPTH = pfrt_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire pfrt_pkg::entry_t wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output pfrt_pkg::entry_t      rdata
);
	import pfrt_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_packet_filter_rule_table_unit.sv =====
// self-checking testbench for the packet filter rule table unit
`default_nettype none

module tb_packet_filter_rule_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pfrt_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 410;
	localparam int BLOCK_ITEMS = 150;

	typedef struct {
		in_t  item;
		bit   fixed;
		out_t res;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	logic [31:0] acl_addr [DEPTH];
	logic [7:0]  acl_proto [DEPTH];
	logic [15:0] acl_port [DEPTH];
	bit          acl_live [DEPTH];
	logic [COUNT_OUT_W-1:0] acl_total = '0;

	out_t verdict_q [$];
	int unsigned fault_count = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	packet_filter_rule_table_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic out_t apply_acl_op(in_t it);
		out_t r;
		bit l4;
		int k;
		r = '0;
		l4 = (it.protocol == PROTO_TCP) || (it.protocol == PROTO_UDP);
		case (it.func)
			FN_CHECK: begin
				for (k = 0; k < DEPTH; k++) begin
					if (acl_live[k] &&
						(acl_addr[k] == 32'd0 || acl_addr[k] == it.ip_addr) &&
						(acl_proto[k] == 8'd0 || acl_proto[k] == it.protocol) &&
						(acl_port[k] == 16'd0 || (l4 && acl_port[k] == it.port))) begin
						r.drop = 1'b1;
						break;
					end
				end
			end
			FN_ADD: begin
				r.status = ST_FULL;
				for (k = 0; k < DEPTH; k++) begin
					if (!acl_live[k]) begin
						acl_addr[k] = it.ip_addr;
						acl_proto[k] = it.protocol;
						acl_port[k] = it.port;
						acl_live[k] = 1'b1;
						acl_total++;
						r.status = ST_OK;
						break;
					end
				end
			end
			FN_DEL: begin
				r.status = ST_MISSING;
				for (k = 0; k < DEPTH; k++) begin
					if (acl_live[k] && acl_addr[k] == it.ip_addr &&
						acl_proto[k] == it.protocol && acl_port[k] == it.port) begin
						acl_live[k] = 1'b0;
						if (acl_total != 0)
							acl_total--;
						r.status = ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		r.rule_count = acl_total;
		return r;
	endfunction

	function automatic int pick_live();
		int live [$];
		int k;
		for (k = 0; k < DEPTH; k++)
			if (acl_live[k])
				live.push_back(k);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(live.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_addr();
		logic [31:0] pool [4] = '{32'h0a000001, 32'hc0a80101, 32'h7f000001, 32'h80000000};
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 32'd0;
		if (r == 1)
			return 32'hffffffff;
		if (r < 6)
			return pool[r - 2];
		return $urandom;
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return PROTO_TCP;
			2: return PROTO_UDP;
			3: return 8'hff;
			4: return 8'd1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(6))
			0: return 16'd0;
			1: return 16'd80;
			2: return 16'hffff;
			3: return 16'd443;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic in_t gen_item(bit filling);
		in_t it;
		int roll;
		int k;
		roll = $urandom_range(99);
		it.ip_addr = pick_addr();
		it.protocol = pick_proto();
		it.port = pick_port();
		if (roll < (filling ? 65 : 8)) begin
			it.func = FN_ADD;
			k = pick_live();
			if (k >= 0 && $urandom_range(9) == 0) begin
				it.ip_addr = acl_addr[k];
				it.protocol = acl_proto[k];
				it.port = acl_port[k];
			end
		end else if (roll < (filling ? 85 : 45)) begin
			it.func = FN_CHECK;
			k = pick_live();
			if (k >= 0 && $urandom_range(99) < 65) begin
				if (acl_addr[k] != 32'd0)
					it.ip_addr = acl_addr[k];
				if (acl_proto[k] != 8'd0)
					it.protocol = acl_proto[k];
				else if ($urandom_range(1))
					it.protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
				if (acl_port[k] != 16'd0)
					it.port = acl_port[k];
				if ($urandom_range(3) == 0) begin
					case ($urandom_range(2))
						0: it.ip_addr ^= 32'h1 << $urandom_range(31);
						1: it.protocol ^= 8'h1 << $urandom_range(7);
						default: it.port ^= 16'h1 << $urandom_range(15);
					endcase
				end
			end
		end else if (roll < 95) begin
			it.func = FN_DEL;
			k = pick_live();
			if (k >= 0 && $urandom_range(99) < 75) begin
				it.ip_addr = acl_addr[k];
				it.protocol = acl_proto[k];
				it.port = acl_port[k];
				if ($urandom_range(4) == 0)
					it.port ^= 16'h1 << $urandom_range(15);
			end
		end else begin
			it.func = FN_UNUSED;
		end
		return it;
	endfunction

	function automatic dir_row_t mk_row(logic [1:0] f, logic [31:0] a, logic [7:0] p,
		logic [15:0] d, int fx, int dr, logic [1:0] st, int cnt);
		dir_row_t row;
		row.item.func = f;
		row.item.ip_addr = a;
		row.item.protocol = p;
		row.item.port = d;
		row.fixed = (fx != 0);
		row.res.drop = (dr != 0);
		row.res.status = st;
		row.res.rule_count = COUNT_OUT_W'(cnt);
		return row;
	endfunction

	task automatic send(in_t it, bit fixed, out_t fixed_res);
		out_t pred;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
		pred = apply_acl_op(it);
		verdict_q.push_back(fixed ? fixed_res : pred);
	endtask

	always @(posedge clk) begin : rx_side
		out_t want;
		if (out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected transaction: drop=%0d status=%0d count=%0d",
						out_data.drop, out_data.status, out_data.rule_count);
			end else begin
				want = verdict_q.pop_front();
				if (out_data.drop !== want.drop || out_data.status !== want.status ||
					out_data.rule_count !== want.rule_count) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: exp drop=%0d status=%0d count=%0d, got drop=%0d status=%0d count=%0d",
							want.drop, want.status, want.rule_count,
							out_data.drop, out_data.status, out_data.rule_count);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin : stim
		dir_row_t rows [25];
		int ph;
		int n;
		int k;
		for (k = 0; k < DEPTH; k++) begin
			acl_addr[k] = '0;
			acl_proto[k] = '0;
			acl_port[k] = '0;
			acl_live[k] = 1'b0;
		end
		rows = '{
			mk_row(FN_CHECK, 32'hffffffff, 8'hff, 16'hffff, 1, 0, ST_OK, 0),
			mk_row(FN_DEL, 32'h0, 8'h0, 16'h0, 1, 0, ST_MISSING, 0),
			mk_row(FN_UNUSED, 32'hffffffff, 8'hff, 16'hffff, 1, 0, ST_OK, 0),
			mk_row(FN_ADD, 32'h0, 8'h0, 16'h0, 1, 0, ST_OK, 1),
			mk_row(FN_CHECK, 32'h12345678, 8'd1, 16'h0, 1, 1, ST_OK, 1),
			mk_row(FN_UNUSED, 32'h0, 8'h0, 16'h0, 1, 0, ST_OK, 1),
			mk_row(FN_DEL, 32'h0, 8'h0, 16'h0, 1, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'h0, 8'h0, 16'h0, 1, 0, ST_OK, 0),
			mk_row(FN_ADD, 32'hffffffff, PROTO_TCP, 16'hffff, 1, 0, ST_OK, 1),
			mk_row(FN_CHECK, 32'hffffffff, PROTO_TCP, 16'hffff, 0, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'hffffffff, PROTO_UDP, 16'hffff, 0, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'hfffffffe, PROTO_TCP, 16'hffff, 0, 0, ST_OK, 0),
			mk_row(FN_ADD, 32'h0, 8'h0, 16'd80, 1, 0, ST_OK, 2),
			mk_row(FN_CHECK, 32'h0a000001, 8'd1, 16'd80, 0, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'h0a000001, PROTO_UDP, 16'd80, 0, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'h0a000001, PROTO_TCP, 16'd81, 0, 0, ST_OK, 0),
			mk_row(FN_ADD, 32'h0a000001, 8'h0, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_ADD, 32'h0a000001, 8'h0, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_DEL, 32'h0a000001, 8'h0, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'h0a000001, 8'hff, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_DEL, 32'h0a000001, 8'h0, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_DEL, 32'h0a000001, 8'h0, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_ADD, 32'h0, 8'hff, 16'h0, 0, 0, ST_OK, 0),
			mk_row(FN_CHECK, 32'h0, 8'hff, 16'hffff, 0, 0, ST_OK, 0),
			mk_row(FN_UNUSED, 32'h0a000001, PROTO_TCP, 16'd80, 0, 0, ST_OK, 0)
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i])
			send(rows[i].item, rows[i].fixed, rows[i].res);
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 67; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 67; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			// alternate table fill and drain so full and empty states recur
			for (n = 0; n < PHASE_ITEMS; n++)
				send(gen_item(((n / BLOCK_ITEMS) % 2) == 0), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
